// ===== hdl/modbus_response_checker_assert.svh =====
// ----------------------------------------------------------------------------
// Modbus response checker assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RESPONSE_CHECKER_ASSERT_SVH
`define MODBUS_RESPONSE_CHECKER_ASSERT_SVH

// same-cycle implication
`define MRC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mrc assertion failed");

// next-cycle implication
`define MRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mrc assertion failed");

`endif

// ===== hdl/mrc_pkg.sv =====
// ----------------------------------------------------------------------------
// mrc_pkg
// Types, codes and constants shared by the Modbus response checker.
// ----------------------------------------------------------------------------
package mrc_pkg;

    localparam logic [6:0] C_MAX_REGISTERS = 7'd125;
    localparam int         C_QUEUE_DEPTH   = 4;

    localparam logic [7:0] C_FUNC_READ_HOLDING = 8'h03;
    localparam logic [7:0] C_FUNC_WRITE_SINGLE = 8'h06;
    localparam logic [7:0] C_FUNC_EXCEPTION    = 8'h80;
    localparam logic [15:0] C_CRC_INIT         = 16'hFFFF;
    localparam logic [15:0] C_CRC_POLY         = 16'hA001;

    // configuration register indexes
    localparam logic [2:0] C_REG_REPLY_MODE     = 3'd0;
    localparam logic [2:0] C_REG_SLAVE_ADDRESS  = 3'd1;
    localparam logic [2:0] C_REG_REGISTER_COUNT = 3'd2;
    localparam logic [2:0] C_REG_WRITE_ADDRESS  = 3'd3;
    localparam logic [2:0] C_REG_WRITE_VALUE    = 3'd4;

    localparam logic C_MODE_READ  = 1'b0;
    localparam logic C_MODE_WRITE = 1'b1;

    localparam logic C_KIND_WORD   = 1'b0;
    localparam logic C_KIND_STATUS = 1'b1;

    localparam logic [2:0] C_ST_OK        = 3'd0;
    localparam logic [2:0] C_ST_PARAMETER = 3'd1;
    localparam logic [2:0] C_ST_FRAME     = 3'd2;
    localparam logic [2:0] C_ST_CRC       = 3'd3;
    localparam logic [2:0] C_ST_EXCEPTION = 3'd4;

    typedef struct packed {
        logic        reply_mode;
        logic [7:0]  slave_address;
        logic [6:0]  register_count;
        logic [15:0] write_address;
        logic [15:0] write_value;
    } t_cfg;

    typedef struct packed {
        logic        result_kind;
        logic [6:0]  register_index;
        logic [15:0] register_word;
        logic [2:0]  frame_status;
        logic        is_last;
    } t_result;

    // results produced by one byte, word first
    typedef struct packed {
        logic    word_valid;
        t_result word;
        logic    status_valid;
        t_result status;
    } t_push;

endpackage

// ===== hdl/mrc_ifs.sv =====
// ----------------------------------------------------------------------------
// mrc interfaces
// Valid/ready channels for received bytes, results and register writes.
// ----------------------------------------------------------------------------
interface mrc_rx_if import mrc_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       end_of_frame;

    modport source (output valid, output rx_byte, output end_of_frame, input ready);
    modport sink   (input valid, input rx_byte, input end_of_frame, output ready);
endinterface

interface mrc_res_if import mrc_pkg::*; ();
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [6:0]  register_index;
    logic [15:0] register_word;
    logic [2:0]  frame_status;
    logic        is_last;

    modport source (output valid, output result_kind, output register_index,
                    output register_word, output frame_status, output is_last,
                    input ready);
    modport sink   (input valid, input result_kind, input register_index,
                    input register_word, input frame_status, input is_last,
                    output ready);
endinterface

interface mrc_cfg_if import mrc_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/mrc_frame_core.sv =====
// ----------------------------------------------------------------------------
// mrc_frame_core
// Per-byte frame state, CRC update, register word assembly and final status.
// ----------------------------------------------------------------------------
`include "modbus_response_checker_assert.svh"

module mrc_frame_core import mrc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_go,
    input  logic [7:0] i_rx_byte,
    input  logic       i_eof,
    input  t_cfg       i_cfg,
    output t_push      o_push
);

    logic [7:0]  r_pos, n_pos, u_pos;
    logic [15:0] r_crc, n_crc, u_crc;
    logic [15:0] r_rcrc, n_rcrc, u_rcrc;
    logic [7:0]  r_addr, n_addr, u_addr;
    logic [7:0]  r_func, n_func, u_func;
    logic [7:0]  r_cnt, n_cnt, u_cnt;
    logic [7:0]  r_high, n_high, u_high;
    logic [15:0] r_eaddr, n_eaddr, u_eaddr;
    logic [15:0] r_evalue, n_evalue, u_evalue;

    logic [9:0]  w_p;
    logic [9:0]  w_e;
    logic [7:0]  w_twice;
    logic        w_bad;
    logic        w_in_words;
    logic [7:0]  w_pm4;
    logic [2:0]  w_status;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ C_CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    assign w_twice = {i_cfg.register_count, 1'b0};
    assign w_p     = {2'b00, r_pos};
    assign w_e     = (i_cfg.reply_mode == C_MODE_WRITE) ? 10'd8 : (10'd5 + {2'b00, w_twice});
    assign w_bad   = (i_cfg.register_count == 7'd0) ||
                     (i_cfg.register_count > C_MAX_REGISTERS);
    assign w_pm4   = r_pos - 8'd4;
    assign w_in_words = (i_cfg.reply_mode == C_MODE_READ) && !w_bad &&
                        (r_pos >= 8'd3) && ((w_p + 10'd3) <= w_e) && (r_pos != 8'hFF);

    // frame state after this byte, before any end-of-frame reload
    always_comb begin
        u_pos    = r_pos;
        u_crc    = r_crc;
        u_rcrc   = r_rcrc;
        u_addr   = r_addr;
        u_func   = r_func;
        u_cnt    = r_cnt;
        u_high   = r_high;
        u_eaddr  = r_eaddr;
        u_evalue = r_evalue;
        if (r_pos != 8'hFF) begin
            if ((w_p + 10'd2) < w_e) begin
                u_crc = crc_byte(r_crc, i_rx_byte);
            end else if ((w_p + 10'd2) == w_e) begin
                u_rcrc = {r_rcrc[15:8], i_rx_byte};
            end else if ((w_p + 10'd1) == w_e) begin
                u_rcrc = {i_rx_byte, r_rcrc[7:0]};
            end
            unique case (r_pos)
                8'd0: u_addr = i_rx_byte;
                8'd1: u_func = i_rx_byte;
                8'd2: begin
                    u_cnt   = i_rx_byte;
                    u_eaddr = {i_rx_byte, r_eaddr[7:0]};
                end
                8'd3: u_eaddr  = {r_eaddr[15:8], i_rx_byte};
                8'd4: u_evalue = {i_rx_byte, r_evalue[7:0]};
                8'd5: u_evalue = {r_evalue[15:8], i_rx_byte};
                default: ;
            endcase
            if (w_in_words && r_pos[0]) begin
                u_high = i_rx_byte;
            end
            u_pos = r_pos + 8'd1;
        end
    end

    always_comb begin
        w_status = C_ST_OK;
        if (i_cfg.reply_mode == C_MODE_READ) begin
            priority if (w_bad)                                 w_status = C_ST_PARAMETER;
            else if ({2'b00, u_pos} < w_e)                      w_status = C_ST_FRAME;
            else if (u_crc != u_rcrc)                           w_status = C_ST_CRC;
            else if (u_addr != i_cfg.slave_address)             w_status = C_ST_FRAME;
            else if ((u_func & C_FUNC_EXCEPTION) != 8'h00)      w_status = C_ST_EXCEPTION;
            else if (u_func != C_FUNC_READ_HOLDING)             w_status = C_ST_FRAME;
            else if (u_cnt != w_twice)                          w_status = C_ST_FRAME;
            else                                                w_status = C_ST_OK;
        end else begin
            priority if (u_pos < 8'd8)                          w_status = C_ST_PARAMETER;
            else if (u_crc != u_rcrc)                           w_status = C_ST_CRC;
            else if ((u_addr != i_cfg.slave_address) ||
                     (u_func != C_FUNC_WRITE_SINGLE))           w_status = C_ST_FRAME;
            else if ((u_eaddr != i_cfg.write_address) ||
                     (u_evalue != i_cfg.write_value))           w_status = C_ST_FRAME;
            else                                                w_status = C_ST_OK;
        end
    end

    always_comb begin
        o_push.word_valid          = i_go && w_in_words && !r_pos[0];
        o_push.word.result_kind    = C_KIND_WORD;
        o_push.word.register_index = w_pm4[7:1];
        o_push.word.register_word  = {r_high, i_rx_byte};
        o_push.word.frame_status   = C_ST_OK;
        o_push.word.is_last        = 1'b0;

        o_push.status_valid          = i_go && i_eof;
        o_push.status.result_kind    = C_KIND_STATUS;
        o_push.status.register_index = 7'd0;
        o_push.status.register_word  = 16'd0;
        o_push.status.frame_status   = w_status;
        o_push.status.is_last        = 1'b1;
    end

    always_comb begin
        n_pos    = r_pos;
        n_crc    = r_crc;
        n_rcrc   = r_rcrc;
        n_addr   = r_addr;
        n_func   = r_func;
        n_cnt    = r_cnt;
        n_high   = r_high;
        n_eaddr  = r_eaddr;
        n_evalue = r_evalue;
        if (i_go) begin
            if (i_eof) begin
                // reload for the next frame
                n_pos    = 8'd0;
                n_crc    = C_CRC_INIT;
                n_rcrc   = 16'd0;
                n_addr   = 8'd0;
                n_func   = 8'd0;
                n_cnt    = 8'd0;
                n_high   = 8'd0;
                n_eaddr  = 16'd0;
                n_evalue = 16'd0;
            end else begin
                n_pos    = u_pos;
                n_crc    = u_crc;
                n_rcrc   = u_rcrc;
                n_addr   = u_addr;
                n_func   = u_func;
                n_cnt    = u_cnt;
                n_high   = u_high;
                n_eaddr  = u_eaddr;
                n_evalue = u_evalue;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= 8'd0;
            r_crc    <= C_CRC_INIT;
            r_rcrc   <= 16'd0;
            r_addr   <= 8'd0;
            r_func   <= 8'd0;
            r_cnt    <= 8'd0;
            r_high   <= 8'd0;
            r_eaddr  <= 16'd0;
            r_evalue <= 16'd0;
        end else begin
            r_pos    <= n_pos;
            r_crc    <= n_crc;
            r_rcrc   <= n_rcrc;
            r_addr   <= n_addr;
            r_func   <= n_func;
            r_cnt    <= n_cnt;
            r_high   <= n_high;
            r_eaddr  <= n_eaddr;
            r_evalue <= n_evalue;
        end
    end

    `MRC_ASSERT_NEXT(a_eof_reloads, i_clk, i_rst_n, i_go && i_eof, (r_pos == 8'd0) && (r_crc == C_CRC_INIT))
    `MRC_ASSERT_NEXT(a_pos_saturates, i_clk, i_rst_n, i_go && !i_eof && (r_pos == 8'hFF), r_pos == 8'hFF)

endmodule

// ===== hdl/mrc_result_queue.sv =====
// ----------------------------------------------------------------------------
// mrc_result_queue
// Result register queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
`include "modbus_response_checker_assert.svh"

module mrc_result_queue import mrc_pkg::*; #(
    parameter int DEPTH = C_QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_push        i_push,
    output logic         o_room,
    mrc_res_if.source    o_res
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX  = IW'(DEPTH - 1);
    localparam logic [CW-1:0] ROOM_MAX  = CW'(DEPTH - 2);

    t_result       r_mem [DEPTH];
    logic [IW-1:0] r_head, n_head;
    logic [IW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] w_tail1;
    logic [IW-1:0] w_status_idx;
    logic          w_pop;
    logic [1:0]    w_npush;

    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] idx);
        return (idx == LAST_IDX) ? '0 : (idx + 1'b1);
    endfunction

    assign o_room       = (r_count <= ROOM_MAX);
    assign w_pop        = o_res.valid && o_res.ready;
    assign w_tail1      = wrap_inc(r_tail);
    assign w_status_idx = i_push.word_valid ? w_tail1 : r_tail;
    assign w_npush      = {1'b0, i_push.word_valid} + {1'b0, i_push.status_valid};

    always_comb begin
        n_head  = w_pop ? wrap_inc(r_head) : r_head;
        n_tail  = r_tail;
        if (i_push.status_valid) begin
            n_tail = wrap_inc(w_status_idx);
        end else if (i_push.word_valid) begin
            n_tail = w_tail1;
        end
        n_count = r_count + CW'(w_npush) - CW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.word_valid) begin
            r_mem[r_tail] <= i_push.word;
        end
        if (i_push.status_valid) begin
            r_mem[w_status_idx] <= i_push.status;
        end
    end

    assign o_res.valid          = (r_count != '0);
    assign o_res.result_kind    = r_mem[r_head].result_kind;
    assign o_res.register_index = r_mem[r_head].register_index;
    assign o_res.register_word  = r_mem[r_head].register_word;
    assign o_res.frame_status   = r_mem[r_head].frame_status;
    assign o_res.is_last        = r_mem[r_head].is_last;

    `MRC_ASSERT_IMPLY(a_push_has_room, i_clk, i_rst_n, w_npush != 2'd0, r_count <= ROOM_MAX)
    `MRC_ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH))

endmodule

// ===== hdl/modbus_response_checker.sv =====
// ----------------------------------------------------------------------------
// modbus_response_checker
// Modbus RTU reply checker: register words and a final frame status.
// ----------------------------------------------------------------------------
// Takes one reply byte per cycle. A byte is held in an input register while
// the frame logic updates the CRC and field state, then its results (a
// register word in read mode, and a status on the flagged last byte) land in
// a small result queue. The byte side stalls only when the queue has fewer
// than two free entries, which happens when the result side is held off;
// with the result side ready, a byte is taken every cycle. Register writes
// are taken at any time and apply to the bytes processed after them.
// ----------------------------------------------------------------------------
module modbus_response_checker import mrc_pkg::*; #(
    parameter int QUEUE_DEPTH = C_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mrc_rx_if.sink      i_rx,
    mrc_res_if.source   o_res,
    mrc_cfg_if.sink     i_cfg
);

    t_cfg       r_cfg, n_cfg;
    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eof;
    logic       w_room;
    logic       w_go;
    logic       w_take;
    t_push      w_push;

    // config port never stalls
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                C_REG_REPLY_MODE:     n_cfg.reply_mode     = i_cfg.data[0];
                C_REG_SLAVE_ADDRESS:  n_cfg.slave_address  = i_cfg.data[7:0];
                C_REG_REGISTER_COUNT: n_cfg.register_count = i_cfg.data[6:0];
                C_REG_WRITE_ADDRESS:  n_cfg.write_address  = i_cfg.data;
                C_REG_WRITE_VALUE:    n_cfg.write_value    = i_cfg.data;
                default: ;
            endcase
        end
    end

    // advance the held byte only when the queue can take both results
    assign w_go        = r_in_valid && w_room;
    assign i_rx.ready  = !r_in_valid || w_room;
    assign w_take      = i_rx.valid && i_rx.ready;
    assign n_in_valid  = w_take || (r_in_valid && !w_go);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reply_mode     <= C_MODE_READ;
            r_cfg.slave_address  <= 8'd1;
            r_cfg.register_count <= 7'd1;
            r_cfg.write_address  <= 16'd0;
            r_cfg.write_value    <= 16'd0;
            r_in_valid           <= 1'b0;
        end else begin
            r_cfg      <= n_cfg;
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_byte <= i_rx.rx_byte;
            r_in_eof  <= i_rx.end_of_frame;
        end
    end

    mrc_frame_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (w_go),
        .i_rx_byte (r_in_byte),
        .i_eof     (r_in_eof),
        .i_cfg     (r_cfg),
        .o_push    (w_push)
    );

    mrc_result_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_res   (o_res)
    );

endmodule

// ===== dv/tb_modbus_response_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modbus_response_checker
// Self-checking bench: directed reply frames from a stimulus table, then
// random read and write replies (good, corrupted, short, long and noise)
// under several register settings, checked word by word against a predictor.
// ----------------------------------------------------------------------------
module tb_modbus_response_checker import mrc_pkg::*; ();

    localparam int SETTLE_CYCLES  = 6;
    localparam int RANDOM_BYTES   = 1550;
    localparam int SEGMENT_BYTES  = 110;
    localparam int LONG_HOLD      = 400;
    localparam int PRESSURE_SEG   = 6;

    typedef enum logic [1:0] {ROW_BYTE, ROW_CRC_LO, ROW_CRC_HI, ROW_CONFIG} t_row_kind;

    // value is the byte, the XOR mask on a CRC byte, or the register data
    typedef struct {
        t_row_kind   kind;
        logic [15:0] value;
        logic        eof;
        logic        typed;
        logic [2:0]  status;
        logic [2:0]  reg_index;
    } t_step_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mrc_rx_if  rx_if();
    mrc_res_if res_if();
    mrc_cfg_if cfg_if();

    modbus_response_checker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor copy of the registers and of the frame state
    t_cfg        reg_shadow;
    logic [7:0]  pos;
    logic [15:0] crc_acc;
    logic [15:0] crc_rx;
    logic [7:0]  addr_b;
    logic [7:0]  func_b;
    logic [7:0]  count_b;
    logic [7:0]  high_b;
    logic [15:0] echo_addr;
    logic [15:0] echo_val;

    t_result     expected_results[$];
    logic [7:0]  frame_bytes[$];
    t_step_row   directed_rows[$];

    int error_count       = 0;
    int send_idle_pct     = 0;
    int recv_idle_pct     = 0;
    int hold_left         = 0;
    int cur_seg           = -1;
    bit hold_done         = 1'b0;

    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ C_CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic bit count_invalid();
        return reg_shadow.register_count == 7'd0 || reg_shadow.register_count > C_MAX_REGISTERS;
    endfunction

    function automatic int frame_len();
        return (reg_shadow.reply_mode == C_MODE_WRITE) ? 8 :
               5 + 2 * int'(reg_shadow.register_count);
    endfunction

    function automatic void clear_frame();
        pos       = 8'd0;
        crc_acc   = C_CRC_INIT;
        crc_rx    = 16'd0;
        addr_b    = 8'd0;
        func_b    = 8'd0;
        count_b   = 8'd0;
        high_b    = 8'd0;
        echo_addr = 16'd0;
        echo_val  = 16'd0;
    endfunction

    function automatic logic [2:0] frame_verdict();
        if (reg_shadow.reply_mode == C_MODE_READ) begin
            if (count_invalid()) return C_ST_PARAMETER;
            if (int'(pos) < frame_len()) return C_ST_FRAME;
            if (crc_acc != crc_rx) return C_ST_CRC;
            if (addr_b != reg_shadow.slave_address) return C_ST_FRAME;
            if ((func_b & C_FUNC_EXCEPTION) != 8'd0) return C_ST_EXCEPTION;
            if (func_b != C_FUNC_READ_HOLDING) return C_ST_FRAME;
            if ({1'b0, count_b} != {reg_shadow.register_count, 1'b0}) return C_ST_FRAME;
            return C_ST_OK;
        end
        if (pos < 8'd8) return C_ST_PARAMETER;
        if (crc_acc != crc_rx) return C_ST_CRC;
        if (addr_b != reg_shadow.slave_address || func_b != C_FUNC_WRITE_SINGLE)
            return C_ST_FRAME;
        if (echo_addr != reg_shadow.write_address || echo_val != reg_shadow.write_value)
            return C_ST_FRAME;
        return C_ST_OK;
    endfunction

    // advance the frame state by one accepted byte and queue what it yields
    function automatic void predict_byte(input logic [7:0] b, input logic eof);
        int      p;
        int      e;
        t_result r;
        p = int'(pos);
        e = frame_len();
        if (p < 255) begin
            if (p + 2 < e) begin
                crc_acc = crc16_update(crc_acc, b);
            end else if (p + 2 == e) begin
                crc_rx[7:0] = b;
            end else if (p + 1 == e) begin
                crc_rx[15:8] = b;
            end
            case (p)
                0: addr_b = b;
                1: func_b = b;
                2: begin
                    count_b = b;
                    echo_addr[15:8] = b;
                end
                3: echo_addr[7:0] = b;
                4: echo_val[15:8] = b;
                5: echo_val[7:0] = b;
                default: ;
            endcase
            if (reg_shadow.reply_mode == C_MODE_READ && !count_invalid() && p >= 3 && p + 3 <= e) begin
                if ((p & 1) != 0) begin
                    high_b = b;
                end else begin
                    r = '{result_kind: C_KIND_WORD, register_index: 7'((p - 4) >> 1),
                          register_word: {high_b, b}, frame_status: C_ST_OK, is_last: 1'b0};
                    expected_results.push_back(r);
                end
            end
            pos = 8'(p + 1);
        end
        if (eof) begin
            r = '{result_kind: C_KIND_STATUS, register_index: 7'd0, register_word: 16'd0,
                  frame_status: frame_verdict(), is_last: 1'b1};
            expected_results.push_back(r);
            clear_frame();
        end
    endfunction

    task automatic report(input string field, input logic [15:0] exp_v, input logic [15:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, exp_v, got_v);
            error_count++;
        end
    endtask

    task automatic check_result();
        t_result exp_r;
        if (expected_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, got kind %b status %0d word %h",
                     $time, res_if.result_kind, res_if.frame_status, res_if.register_word);
            error_count++;
        end else begin
            exp_r = expected_results.pop_front();
            report("result_kind", 16'(exp_r.result_kind), 16'(res_if.result_kind));
            report("register_index", 16'(exp_r.register_index), 16'(res_if.register_index));
            report("register_word", exp_r.register_word, res_if.register_word);
            report("frame_status", 16'(exp_r.frame_status), 16'(res_if.frame_status));
            report("is_last", 16'(exp_r.is_last), 16'(res_if.is_last));
        end
    endtask

    // result side: check accepted words, then pick ready for the next cycle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) check_result();
            if (cur_seg == PRESSURE_SEG && !hold_done) begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eof, input logic typed,
                             input logic [2:0] status);
        t_result r;
        while ($urandom_range(99) < send_idle_pct) begin
            rx_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_if.valid        <= 1'b1;
        rx_if.rx_byte      <= b;
        rx_if.end_of_frame <= eof;
        do @(posedge i_clk); while (!rx_if.ready);
        predict_byte(b, eof);
        if (typed && eof) begin
            r = expected_results.pop_back();
            r.frame_status = status;
            expected_results.push_back(r);
        end
    endtask

    // drop valid, wait for every result, then let the pipeline empty
    task automatic wait_drain();
        rx_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_settings(input t_cfg s);
        logic [2:0]  idx [5];
        logic [15:0] val [5];
        idx[0] = C_REG_REPLY_MODE;     val[0] = {15'd0, s.reply_mode};
        idx[1] = C_REG_SLAVE_ADDRESS;  val[1] = {8'd0, s.slave_address};
        idx[2] = C_REG_REGISTER_COUNT; val[2] = {9'd0, s.register_count};
        idx[3] = C_REG_WRITE_ADDRESS;  val[3] = s.write_address;
        idx[4] = C_REG_WRITE_VALUE;    val[4] = s.write_value;
        for (int i = 0; i < 5; i++) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= idx[i];
            cfg_if.data  <= val[i];
            do @(posedge i_clk); while (!cfg_if.ready);
        end
        cfg_if.valid <= 1'b0;
        reg_shadow = s;
    endtask

    function automatic t_cfg pick_settings(input int seg);
        t_cfg        s;
        int unsigned roll;
        s.reply_mode    = 1'($urandom_range(1));
        s.slave_address = 8'($urandom_range(255));
        s.write_address = 16'($urandom_range(65535));
        s.write_value   = 16'($urandom_range(65535));
        roll = $urandom_range(99);
        if (roll < 75) begin
            s.register_count = 7'($urandom_range(6, 1));
        end else if (roll < 88) begin
            s.register_count = 7'($urandom_range(30, 7));
        end else begin
            roll = $urandom_range(2);
            s.register_count = (roll == 0) ? 7'd0 : 7'(125 + roll);
        end
        case (seg)
            0: begin
                s.reply_mode = C_MODE_READ;
                s.slave_address = 8'h00;
                s.register_count = C_MAX_REGISTERS;
            end
            1: begin
                s.reply_mode = C_MODE_WRITE;
                s.slave_address = 8'hFF;
                s.write_address = 16'hFFFF;
                s.write_value = 16'hFFFF;
            end
            2: begin
                s.reply_mode = C_MODE_WRITE;
                s.slave_address = 8'h00;
                s.write_address = 16'h0000;
                s.write_value = 16'h0000;
            end
            3: begin
                s.reply_mode = C_MODE_READ;
                s.register_count = 7'd0;
            end
            4: begin
                s.reply_mode = C_MODE_READ;
                s.register_count = 7'd127;
            end
            5: begin
                s.reply_mode = C_MODE_READ;
                s.slave_address = 8'hFF;
                s.register_count = 7'd1;
            end
            default: ;
        endcase
        return s;
    endfunction

    // well-formed reply for the current settings with an occasional defect, or random noise bytes
    task automatic build_frame();
        int unsigned roll;
        int          len;
        int          target;
        logic [15:0] crc;
        frame_bytes.delete();
        roll = $urandom_range(99);
        if ((reg_shadow.reply_mode == C_MODE_READ && count_invalid()) || roll >= 95) begin
            repeat ($urandom_range(12, 1)) frame_bytes.push_back(8'($urandom_range(255)));
            return;
        end
        len = frame_len();
        frame_bytes.push_back(reg_shadow.slave_address);
        if (reg_shadow.reply_mode == C_MODE_WRITE) begin
            frame_bytes.push_back(C_FUNC_WRITE_SINGLE);
            frame_bytes.push_back(reg_shadow.write_address[15:8]);
            frame_bytes.push_back(reg_shadow.write_address[7:0]);
            frame_bytes.push_back(reg_shadow.write_value[15:8]);
            frame_bytes.push_back(reg_shadow.write_value[7:0]);
        end else begin
            frame_bytes.push_back(C_FUNC_READ_HOLDING);
            frame_bytes.push_back({reg_shadow.register_count, 1'b0});
            repeat (2 * int'(reg_shadow.register_count))
                frame_bytes.push_back(8'($urandom_range(255)));
        end
        if (roll >= 50 && roll < 57) begin
            frame_bytes[0] = frame_bytes[0] ^ 8'($urandom_range(255, 1));
        end else if (roll < 63 && roll >= 57) begin
            frame_bytes[1] = frame_bytes[1] | C_FUNC_EXCEPTION;
        end else if (roll < 67 && roll >= 63) begin
            frame_bytes[1] = 8'($urandom_range(255));
        end else if (roll < 73 && roll >= 67) begin
            frame_bytes[2] = frame_bytes[2] ^ 8'($urandom_range(255, 1));
        end else if (roll < 78 && roll >= 73) begin
            frame_bytes[len - 3] = frame_bytes[len - 3] ^ 8'($urandom_range(255, 1));
        end
        crc = C_CRC_INIT;
        foreach (frame_bytes[k]) crc = crc16_update(crc, frame_bytes[k]);
        if (roll >= 78 && roll < 84) crc = crc ^ (16'd1 << $urandom_range(15));
        frame_bytes.push_back(crc[7:0]);
        frame_bytes.push_back(crc[15:8]);
        if (roll >= 84 && roll < 90) begin
            target = $urandom_range(frame_bytes.size() - 1, 1);
            while (frame_bytes.size() > target) void'(frame_bytes.pop_back());
        end else if (roll >= 90 && roll < 95) begin
            // now and then run past the saturation point of the byte counter
            if ($urandom_range(7) == 0) begin
                target = 260;
            end else begin
                target = frame_bytes.size() + $urandom_range(6, 1);
            end
            while (frame_bytes.size() < target) frame_bytes.push_back(8'($urandom_range(255)));
        end
    endtask

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        t_step_row row;
        t_cfg      s;
        int        random_sent;
        int        seg;
        int        seg_bytes;

        i_rst_n            = 1'b0;
        rx_if.valid        = 1'b0;
        rx_if.rx_byte      = 8'd0;
        rx_if.end_of_frame = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = C_REG_REPLY_MODE;
        cfg_if.data        = 16'd0;

        reg_shadow = '{reply_mode: C_MODE_READ, slave_address: 8'd1, register_count: 7'd1,
                       write_address: 16'd0, write_value: 16'd0};
        clear_frame();

        directed_rows = '{
            // good read reply after reset, word 0xFFFF
            '{ROW_BYTE,   16'h01, 1'b0, 1'b0, C_ST_OK,        C_REG_REPLY_MODE},
            '{ROW_BYTE,   16'h03, 1'b0, 1'b0, C_ST_OK,        C_REG_REPLY_MODE},
            '{ROW_BYTE,   16'h02, 1'b0, 1'b0, C_ST_OK,        C_REG_REPLY_MODE},
            '{ROW_BYTE,   16'hFF, 1'b0, 1'b0, C_ST_OK,        C_REG_REPLY_MODE},
            '{ROW_BYTE,   16'hFF, 1'b0, 1'b0, C_ST_OK,        C_REG_REPLY_MODE},
            '{ROW_CRC_LO, 16'h00, 1'b0, 1'b0, C_ST_OK,        C_REG_REPLY_MODE},
            '{ROW_CRC_HI, 16'h00, 1'b1, 1'b1, C_ST_OK,        C_REG_REPLY_MODE},
            // flag on the low byte of a word: word, then a short frame status
            '{ROW_BYTE,   16'h01, 1'b0, 1'b0, C_ST_OK,        C_REG_REPLY_MODE},
            '{ROW_BYTE,   16'h03, 1'b0, 1'b0, C_ST_OK,        C_REG_REPLY_MODE},
            '{ROW_BYTE,   16'h02, 1'b0, 1'b0, C_ST_OK,        C_REG_REPLY_MODE},
            '{ROW_BYTE,   16'h12, 1'b0, 1'b0, C_ST_OK,        C_REG_REPLY_MODE},
            '{ROW_BYTE,   16'h34, 1'b1, 1'b1, C_ST_FRAME,     C_REG_REPLY_MODE},
            // corrupted CRC, word 0x0000
            '{ROW_BYTE,   16'h01, 1'b0, 1'b0, C_ST_OK,        C_REG_REPLY_MODE},
            '{ROW_BYTE,   16'h03, 1'b0, 1'b0, C_ST_OK,        C_REG_REPLY_MODE},
            '{ROW_BYTE,   16'h02, 1'b0, 1'b0, C_ST_OK,        C_REG_REPLY_MODE},
            '{ROW_BYTE,   16'h00, 1'b0, 1'b0, C_ST_OK,        C_REG_REPLY_MODE},
            '{ROW_BYTE,   16'h00, 1'b0, 1'b0, C_ST_OK,        C_REG_REPLY_MODE},
            '{ROW_CRC_LO, 16'h01, 1'b0, 1'b0, C_ST_OK,        C_REG_REPLY_MODE},
            '{ROW_CRC_HI, 16'h00, 1'b1, 1'b1, C_ST_CRC,       C_REG_REPLY_MODE},
            // device exception bit in the function byte
            '{ROW_BYTE,   16'h01, 1'b0, 1'b0, C_ST_OK,        C_REG_REPLY_MODE},
            '{ROW_BYTE,   16'h83, 1'b0, 1'b0, C_ST_OK,        C_REG_REPLY_MODE},
            '{ROW_BYTE,   16'h02, 1'b0, 1'b0, C_ST_OK,        C_REG_REPLY_MODE},
            '{ROW_BYTE,   16'h80, 1'b0, 1'b0, C_ST_OK,        C_REG_REPLY_MODE},
            '{ROW_BYTE,   16'h01, 1'b0, 1'b0, C_ST_OK,        C_REG_REPLY_MODE},
            '{ROW_CRC_LO, 16'h00, 1'b0, 1'b0, C_ST_OK,        C_REG_REPLY_MODE},
            '{ROW_CRC_HI, 16'h00, 1'b1, 1'b1, C_ST_EXCEPTION, C_REG_REPLY_MODE},
            // zero register count: parameter error, no words
            '{ROW_CONFIG, 16'h00, 1'b0, 1'b0, C_ST_OK,        C_REG_REGISTER_COUNT},
            '{ROW_BYTE,   16'h01, 1'b1, 1'b1, C_ST_PARAMETER, C_REG_REPLY_MODE},
            // write echo cut short
            '{ROW_CONFIG, 16'h01, 1'b0, 1'b0, C_ST_OK,        C_REG_REPLY_MODE},
            '{ROW_BYTE,   16'h01, 1'b0, 1'b0, C_ST_OK,        C_REG_REPLY_MODE},
            '{ROW_BYTE,   16'h06, 1'b1, 1'b1, C_ST_PARAMETER, C_REG_REPLY_MODE}
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 35;
        recv_idle_pct = 56;
        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            case (row.kind)
                ROW_CONFIG: begin
                    wait_drain();
                    s = reg_shadow;
                    case (row.reg_index)
                        C_REG_REPLY_MODE:     s.reply_mode     = row.value[0];
                        C_REG_SLAVE_ADDRESS:  s.slave_address  = row.value[7:0];
                        C_REG_REGISTER_COUNT: s.register_count = row.value[6:0];
                        C_REG_WRITE_ADDRESS:  s.write_address  = row.value;
                        default:              s.write_value    = row.value;
                    endcase
                    load_settings(s);
                end
                ROW_CRC_LO: send_byte(crc_acc[7:0] ^ row.value[7:0], row.eof, row.typed, row.status);
                ROW_CRC_HI: send_byte(crc_acc[15:8] ^ row.value[7:0], row.eof, row.typed, row.status);
                default:    send_byte(row.value[7:0], row.eof, row.typed, row.status);
            endcase
        end

        random_sent = 0;
        seg = 0;
        while (random_sent < RANDOM_BYTES) begin
            wait_drain();
            load_settings(pick_settings(seg));
            // the pressure segment holds the result side off so the block backs up
            cur_seg = seg;
            seg_bytes = 0;
            while (seg_bytes < SEGMENT_BYTES) begin
                if (random_sent < RANDOM_BYTES / 3) begin
                    send_idle_pct = 35;
                    recv_idle_pct = 56;
                end else if (random_sent < 2 * RANDOM_BYTES / 3) begin
                    send_idle_pct = 56;
                    recv_idle_pct = 35;
                end else begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                build_frame();
                foreach (frame_bytes[k])
                    send_byte(frame_bytes[k], k == frame_bytes.size() - 1, 1'b0, C_ST_OK);
                seg_bytes += frame_bytes.size();
                random_sent += frame_bytes.size();
            end
            seg++;
        end

        wait_drain();
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
